FILE: hw/rtl/caf_pkg.sv
// caf_pkg: shared types, mode and register codes, and helpers of the color adjust filter
// used by the channel interfaces, the filter and the testbench; depends on nothing
package caf_pkg;

    typedef logic [15:0] chan_t;

    // adjustment modes held in the kind register
    localparam logic [3:0] KIND_FILL     = 4'd0;
    localparam logic [3:0] KIND_HUE      = 4'd1;
    localparam logic [3:0] KIND_SAT      = 4'd2;
    localparam logic [3:0] KIND_VALUE    = 4'd3;
    localparam logic [3:0] KIND_BRIGHT   = 4'd4;
    localparam logic [3:0] KIND_CONTRAST = 4'd5;
    localparam logic [3:0] KIND_RED      = 4'd6;
    localparam logic [3:0] KIND_GREEN    = 4'd7;
    localparam logic [3:0] KIND_BLUE     = 4'd8;

    // configuration register indexes
    localparam logic [2:0] REG_KIND       = 3'd0;
    localparam logic [2:0] REG_STRENGTH   = 3'd1;
    localparam logic [2:0] REG_FILL_RED   = 3'd2;
    localparam logic [2:0] REG_FILL_GREEN = 3'd3;
    localparam logic [2:0] REG_FILL_BLUE  = 3'd4;

    // one in Q.16, and the smallest saturation that is still scaled
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] SAT_MIN = 17'd66;

    // side data that runs next to the dividers
    typedef struct packed {
        logic signed [20:0] f;
        logic [15:0]        mx;
        logic               gray;
        logic               black;
        logic               cpos;
        logic [2:0]         cz;
        logic [2:0]         co;
        logic [2:0][15:0]   direct;
        logic [15:0]        oa;
    } carry_t;

    // saturate a signed value to 0..65535
    function automatic logic [15:0] clamp_u16(input logic signed [39:0] x);
        logic [15:0] r;
        if (x < 0)
            r = 16'h0000;
        else if (x > 40'sd65535)
            r = 16'hFFFF;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/caf_if.sv
// caf_if: valid/ready channels that carry one input word and one result word
// depends on caf_pkg for the channel type
interface caf_in_if;
    import caf_pkg::*;
    logic  valid;
    logic  ready;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
    chan_t in_alpha;
    chan_t weight;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, weight, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_alpha, weight, output ready);
endinterface

interface caf_out_if;
    import caf_pkg::*;
    logic  valid;
    logic  ready;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

FILE: hw/rtl/caf_div.sv
// caf_div: pipelined restoring divider, one quotient bit per stage
// stand-alone; stage enables come from the pipeline control of the caller
module caf_div #(
    parameter int DW = 16,
    parameter int QW = 17
) (
    input  logic                 clk,
    input  logic [QW-1:0]        en,
    input  logic [DW+QW-2:0]     num,
    input  logic [DW-1:0]        den,
    output logic [QW-1:0]        quo
);
    localparam int NW = DW + QW - 1;
    localparam int XW = DW + QW;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [XW-1:0] trial;
        logic          fits;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // trial subtract of the shifted divisor
        assign trial = XW'(den_in) << (QW - 1 - k);
        assign fits  = XW'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= fits ? NW'(XW'(rem_in) - trial) : rem_in;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_in | (fits ? (QW'(1) << (QW - 1 - k)) : QW'(0));
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

FILE: hw/rtl/color_adjust_filter.sv
// Color adjust filter: takes one RGBA color word with its mask weight per clock while the
// result side does not stall, and returns one adjusted color word for each accepted word.
// Most of the pipeline is the 17-stage restoring dividers that produce saturation,
// hue and the contrast quotients; all stages advance independently, so bubbles close up
// and a stalled result holds while earlier stages keep filling. The mode, strength and
// fill color registers are meant to be written only while no word is in flight.
// depends on caf_pkg, caf_if and caf_div
module color_adjust_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    caf_in_if.sink                feed,
    caf_out_if.source             adjusted
);
    import caf_pkg::*;

    localparam int DQW      = 17;
    localparam int ST_IN    = 0;
    localparam int ST_HSV   = 1;
    localparam int ST_PREP  = 2;
    localparam int ST_DIV   = 3;
    localparam int ST_A     = ST_DIV + DQW;
    localparam int ST_B     = ST_A + 1;
    localparam int ST_C     = ST_B + 1;
    localparam int ST_D     = ST_C + 1;
    localparam int ST_OUT   = ST_D + 1;
    localparam int STAGES   = ST_OUT + 1;

    // configuration registers
    logic [3:0]         kind_reg;
    logic signed [15:0] strength_reg;
    logic [2:0][15:0]   fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_FILL;
            strength_reg <= 16'sd4096;
            fill_reg     <= {3{16'hFFFF}};
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_KIND:       kind_reg     <= cfg_wdata[3:0];
                REG_STRENGTH:   strength_reg <= cfg_wdata;
                REG_FILL_RED:   fill_reg[0]  <= cfg_wdata;
                REG_FILL_GREEN: fill_reg[1]  <= cfg_wdata;
                REG_FILL_BLUE:  fill_reg[2]  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // per-stage valid bits and enables: a stage loads when empty or when it drains
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES:0]   en;

    assign en[STAGES] = adjusted.ready;
    for (genvar k = 0; k < STAGES; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign v_next = {v_reg[STAGES-2:0], feed.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_next[k];
            end
        end
    end

    assign feed.ready     = en[ST_IN];
    assign adjusted.valid = v_reg[ST_OUT];

    // input stage: capture color and form weight times strength
    logic [2:0][15:0]   col0_reg;
    logic [15:0]        a0_reg;
    logic signed [32:0] prod0_reg;
    logic signed [32:0] prod0_next;

    assign prod0_next = $signed({1'b0, feed.weight}) * strength_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            col0_reg  <= {feed.in_blue, feed.in_green, feed.in_red};
            a0_reg    <= feed.in_alpha;
            prod0_reg <= prod0_next;
        end
    end

    // factor rounding and rgb to hsv sector terms
    logic [15:0]        r0, g0, b0;
    logic [15:0]        mx_next, mn_next, c_next;
    logic [18:0]        n_next;
    logic signed [20:0] f_next;

    assign r0 = col0_reg[0];
    assign g0 = col0_reg[1];
    assign b0 = col0_reg[2];
    assign f_next = 21'((prod0_reg + 33'sd2048) >>> 12);

    always_comb
    begin
        mx_next = r0;
        mn_next = r0;
        if (g0 > mx_next) mx_next = g0;
        if (b0 > mx_next) mx_next = b0;
        if (g0 < mn_next) mn_next = g0;
        if (b0 < mn_next) mn_next = b0;
        c_next = mx_next - mn_next;
        if (r0 >= g0 && r0 >= b0)
        begin
            if (g0 >= b0)
                n_next = 19'(g0) - 19'(b0);
            else
                n_next = 19'({c_next, 2'b00}) + 19'({c_next, 1'b0}) - (19'(b0) - 19'(g0));
        end
        else if (g0 >= b0)
            n_next = 19'({c_next, 1'b0}) + 19'(b0) - 19'(r0);
        else
            n_next = 19'({c_next, 2'b00}) + 19'(r0) - 19'(g0);
    end

    logic [2:0][15:0]   col1_reg;
    logic [15:0]        a1_reg;
    logic signed [20:0] f1_reg;
    logic [15:0]        mx1_reg;
    logic [15:0]        c1_reg;
    logic [18:0]        n1_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_HSV])
        begin
            col1_reg <= col0_reg;
            a1_reg   <= a0_reg;
            f1_reg   <= f_next;
            mx1_reg  <= mx_next;
            c1_reg   <= c_next;
            n1_reg   <= n_next;
        end
    end

    // divider operands and the results of the modes that need no division
    logic [16:0]               fc;
    logic signed [17:0]        cc;
    logic                      cpos;
    logic [16:0]               cden;
    logic [17:0]               cmn;
    logic [17:0]               c3;
    logic [31:0]               sat_num_next;
    logic [34:0]               hue_num_next;
    logic [18:0]               hue_den_next;
    logic signed [16:0]        fdiff  [3];
    logic signed [34:0]        fprod  [3];
    logic signed [34:0]        fsum   [3];
    logic signed [18:0]        bsum   [3];
    logic signed [21:0]        chsum  [3];
    logic signed [18:0]        cnumv  [3];
    logic [35:0]               cprod  [3];
    logic [18:0]               cres   [3];
    logic [2:0][32:0]          cnum_next;
    logic [34:0]               asum;
    carry_t                    car2_next;

    assign fc   = (f1_reg < 0) ? 17'd0 : ((f1_reg > 21'sd65536) ? ONE_Q16 : f1_reg[16:0]);
    assign cc   = (f1_reg < -21'sd65536) ? -18'sd65536 :
                  ((f1_reg > 21'sd65536) ? 18'sd65536 : f1_reg[17:0]);
    assign cpos = cc > 18'sd0;
    assign cden = {16'(18'sd65536 - cc), 1'b0};
    assign cmn  = 18'(19'sd65536 - 19'(cc));
    assign c3   = 18'({c1_reg, 1'b0}) + 18'(c1_reg);

    assign sat_num_next = {c1_reg, 16'h0000} + 32'(mx1_reg[15:1]);
    assign hue_num_next = {n1_reg, 16'h0000} + 35'(c3);
    assign hue_den_next = 19'({c1_reg, 2'b00}) + 19'({c1_reg, 1'b0});
    assign asum = {3'b000, a1_reg, 16'h0000} + 35'(fc) * 35'(ONE_Q16 - 17'(a1_reg))
                  + 35'd32768;

    always_comb
    begin
        car2_next.f     = f1_reg;
        car2_next.mx    = mx1_reg;
        car2_next.gray  = (c1_reg == 16'h0000);
        car2_next.black = (mx1_reg == 16'h0000);
        car2_next.cpos  = cpos;
        car2_next.oa    = (kind_reg == KIND_FILL) ? clamp_u16(40'(asum >> 16)) : a1_reg;
        for (int i = 0; i < 3; i++)
        begin
            fdiff[i] = $signed({1'b0, fill_reg[i]}) - $signed({1'b0, col1_reg[i]});
            fprod[i] = $signed({1'b0, fc}) * fdiff[i];
            fsum[i]  = 35'($signed({1'b0, col1_reg[i], 16'h0000})) + fprod[i]
                       + 35'sd32768;
            bsum[i]  = $signed({3'b000, col1_reg[i]}) + 19'(cc);
            chsum[i] = $signed({6'b000000, col1_reg[i]}) + 22'(f1_reg);
            cnumv[i] = $signed({2'b00, col1_reg[i], 1'b0}) - 19'(cc);
            cprod[i] = 36'(cmn) * 36'(cnumv[i][17:0]);
            cres[i]  = 19'((cprod[i] + 36'd65536) >> 17);

            cnum_next[i]    = {cnumv[i][16:0], 16'h0000} + 33'(cden[16:1]);
            car2_next.cz[i] = (cnumv[i] <= 19'sd0);
            car2_next.co[i] = (cnum_next[i] >= {cden, 16'h0000});

            case (kind_reg)
                KIND_FILL:     car2_next.direct[i] = clamp_u16(40'(fsum[i] >>> 16));
                KIND_BRIGHT:   car2_next.direct[i] = clamp_u16(40'(bsum[i]));
                KIND_CONTRAST: car2_next.direct[i] = cpos ? 16'h0000 : clamp_u16(40'(cres[i]));
                KIND_RED, KIND_GREEN, KIND_BLUE:
                    car2_next.direct[i] = (kind_reg == KIND_RED + 4'(i)) ?
                                          clamp_u16(40'(chsum[i])) : col1_reg[i];
                default:       car2_next.direct[i] = col1_reg[i];
            endcase
        end
    end

    logic [31:0]      sat_num_reg;
    logic [15:0]      sat_den_reg;
    logic [34:0]      hue_num_reg;
    logic [18:0]      hue_den_reg;
    logic [2:0][32:0] cnum_reg;
    logic [16:0]      cden_reg;
    carry_t           car2_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PREP])
        begin
            sat_num_reg <= sat_num_next;
            sat_den_reg <= mx1_reg;
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            cnum_reg    <= cnum_next;
            cden_reg    <= cden;
            car2_reg    <= car2_next;
        end
    end

    // dividers for saturation, hue and the three contrast channels
    logic [DQW-1:0] sat_q;
    logic [DQW-1:0] hue_q;
    logic [DQW-1:0] con_q [3];

    caf_div #(.DW(16), .QW(DQW)) u_div_sat (
        .clk (clk),
        .en  (en[ST_DIV +: DQW]),
        .num (sat_num_reg),
        .den (sat_den_reg),
        .quo (sat_q)
    );

    caf_div #(.DW(19), .QW(DQW)) u_div_hue (
        .clk (clk),
        .en  (en[ST_DIV +: DQW]),
        .num (hue_num_reg),
        .den (hue_den_reg),
        .quo (hue_q)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_con
        caf_div #(.DW(17), .QW(DQW)) u_div_con (
            .clk (clk),
            .en  (en[ST_DIV +: DQW]),
            .num (cnum_reg[i]),
            .den (cden_reg),
            .quo (con_q[i])
        );
    end

    // side data delay line matched to the dividers
    carry_t car_reg [DQW];

    for (genvar k = 0; k < DQW; k++)
    begin : g_car
        always_ff @(posedge clk)
        begin
            if (en[ST_DIV + k])
                car_reg[k] <= (k == 0) ? car2_reg : car_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // saturation and hue out of the dividers, contrast quotients resolved
    carry_t             cd;
    logic [16:0]        sa_s_next;
    logic [15:0]        sa_h_next;
    logic signed [38:0] sa_ps_next;
    logic [2:0][15:0]   sa_dir_next;

    assign cd         = car_reg[DQW-1];
    assign sa_s_next  = cd.black ? 17'd0 : sat_q;
    assign sa_h_next  = cd.gray ? 16'h0000 : hue_q[15:0];
    assign sa_ps_next = 39'(cd.f) * 39'($signed({1'b0, sa_s_next}));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (kind_reg == KIND_CONTRAST && cd.cpos)
                sa_dir_next[i] = cd.cz[i] ? 16'h0000 :
                                 (cd.co[i] ? 16'hFFFF : con_q[i][15:0]);
            else
                sa_dir_next[i] = cd.direct[i];
        end
    end

    logic [16:0]        sa_s_reg;
    logic [15:0]        sa_h_reg;
    logic signed [38:0] sa_ps_reg;
    logic signed [20:0] sa_f_reg;
    logic [15:0]        sa_mx_reg;
    logic [2:0][15:0]   sa_dir_reg;
    logic [15:0]        sa_oa_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_A])
        begin
            sa_s_reg   <= sa_s_next;
            sa_h_reg   <= sa_h_next;
            sa_ps_reg  <= sa_ps_next;
            sa_f_reg   <= cd.f;
            sa_mx_reg  <= cd.mx;
            sa_dir_reg <= sa_dir_next;
            sa_oa_reg  <= cd.oa;
        end
    end

    // new hue, saturation and value per mode, then hsv sector terms
    function automatic logic [16:0] hue_m(input logic signed [20:0] n);
        logic [16:0] m;
        if (n <= 21'sd0)
            m = ONE_Q16;
        else if (n >= 21'sd65536)
            m = 17'd0;
        else
            m = 17'(21'sd65536 - n);
        return m;
    endfunction

    function automatic logic signed [20:0] abs21(input logic signed [20:0] x);
        return (x < 0) ? -x : x;
    endfunction

    logic signed [38:0] ps_rnd;
    logic signed [39:0] s_sum;
    logic [16:0]        s_new;
    logic signed [21:0] v_sum;
    logic [16:0]        v_new;
    logic signed [20:0] f_abs;
    logic [15:0]        hh;
    logic [16:0]        sb_ss_next;
    logic [16:0]        sb_vv_next;
    logic               sb_use_next;
    logic [18:0]        h6;
    logic signed [20:0] hs;
    logic [2:0][16:0]   sb_m_next;

    assign ps_rnd = (sa_ps_reg + 39'sd32768) >>> 16;
    assign s_sum  = 40'(ps_rnd) + 40'($signed({1'b0, sa_s_reg}));
    assign s_new  = (s_sum < 0) ? 17'd0 : ((s_sum > 40'sd65536) ? ONE_Q16 : s_sum[16:0]);
    assign v_sum  = $signed({6'b000000, sa_mx_reg}) + 22'(sa_f_reg);
    assign v_new  = (v_sum < 0) ? 17'd0 : ((v_sum > 22'sd65536) ? ONE_Q16 : v_sum[16:0]);
    assign f_abs  = abs21(sa_f_reg);

    always_comb
    begin
        hh          = sa_h_reg;
        sb_ss_next  = sa_s_reg;
        sb_vv_next  = 17'(sa_mx_reg);
        sb_use_next = 1'b0;
        case (kind_reg)
            KIND_HUE:
            begin
                hh          = f_abs[15:0];
                sb_use_next = 1'b1;
            end
            KIND_SAT:
            begin
                sb_ss_next  = s_new;
                sb_use_next = (sa_s_reg >= SAT_MIN);
            end
            KIND_VALUE:
            begin
                sb_vv_next  = v_new;
                sb_use_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign h6 = 19'(hh) * 19'd6;
    assign hs = $signed({2'b00, h6});
    assign sb_m_next[0] = hue_m(abs21(hs - 21'sd196608) - 21'sd65536);
    assign sb_m_next[1] = hue_m(21'sd131072 - abs21(hs - 21'sd131072));
    assign sb_m_next[2] = hue_m(21'sd131072 - abs21(hs - 21'sd262144));

    logic [2:0][16:0] sb_m_reg;
    logic [16:0]      sb_ss_reg;
    logic [16:0]      sb_vv_reg;
    logic             sb_use_reg;
    logic [2:0][15:0] sb_dir_reg;
    logic [15:0]      sb_oa_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_B])
        begin
            sb_m_reg   <= sb_m_next;
            sb_ss_reg  <= sb_ss_next;
            sb_vv_reg  <= sb_vv_next;
            sb_use_reg <= sb_use_next;
            sb_dir_reg <= sa_dir_reg;
            sb_oa_reg  <= sa_oa_reg;
        end
    end

    // chroma term: one minus sector weight times saturation
    logic [2:0][32:0] sc_t_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sc_t_next[i] = 33'(34'h1_0000_0000 - 34'(sb_m_reg[i]) * 34'(sb_ss_reg));
    end

    logic [2:0][32:0] sc_t_reg;
    logic [16:0]      sc_vv_reg;
    logic             sc_use_reg;
    logic [2:0][15:0] sc_dir_reg;
    logic [15:0]      sc_oa_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_C])
        begin
            sc_t_reg   <= sc_t_next;
            sc_vv_reg  <= sb_vv_reg;
            sc_use_reg <= sb_use_reg;
            sc_dir_reg <= sb_dir_reg;
            sc_oa_reg  <= sb_oa_reg;
        end
    end

    // scale by value and round
    logic [2:0][16:0] sd_hv_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sd_hv_next[i] = 17'((50'(sc_t_reg[i]) * 50'(sc_vv_reg) + 50'h8000_0000) >> 32);
    end

    logic [2:0][16:0] sd_hv_reg;
    logic             sd_use_reg;
    logic [2:0][15:0] sd_dir_reg;
    logic [15:0]      sd_oa_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_D])
        begin
            sd_hv_reg  <= sd_hv_next;
            sd_use_reg <= sc_use_reg;
            sd_dir_reg <= sc_dir_reg;
            sd_oa_reg  <= sc_oa_reg;
        end
    end

    // output register
    logic [2:0][15:0] out_reg;
    logic [15:0]      oa_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            for (int i = 0; i < 3; i++)
                out_reg[i] <= sd_use_reg ? clamp_u16(40'(sd_hv_reg[i])) : sd_dir_reg[i];
            oa_reg <= sd_oa_reg;
        end
    end

    assign adjusted.out_red   = out_reg[0];
    assign adjusted.out_green = out_reg[1];
    assign adjusted.out_blue  = out_reg[2];
    assign adjusted.out_alpha = oa_reg;

    // the stalled stage before the output keeps its word
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_D] && !en[ST_OUT] |=> v_reg[ST_D])
        else $error("stalled stage lost its word");

    // a full stalled pipeline takes no input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !adjusted.ready |-> !feed.ready)
        else $error("input accepted into a full pipeline");

    // an accepted word occupies the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        feed.valid && feed.ready |=> v_reg[ST_IN])
        else $error("accepted word not captured");

    // a black color has no chroma
    a_black_gray: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_PREP] && car2_reg.black |-> car2_reg.gray)
        else $error("black color with nonzero chroma");

    // rebuilt saturation stays within one
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_B] |-> sb_ss_reg <= ONE_Q16)
        else $error("saturation above one");

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for color_adjust_filter, with a color-adjust predictor
// depends on caf_pkg, caf_if and the color_adjust_filter RTL
`timescale 1ns / 1ps

module testbench;
    import caf_pkg::*;

    localparam longint UNIT = 65536;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int HOLD_PHASE = 8;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        chan_t weight;
    } color_word_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } adjusted_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    caf_in_if  feed_if ();
    caf_out_if res_if ();

    color_adjust_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .feed      (feed_if.sink),
        .adjusted  (res_if.source)
    );

    // bench copy of the configuration
    logic [3:0]  mode_reg;
    logic [15:0] strength_reg;
    logic [15:0] fill_r_reg;
    logic [15:0] fill_g_reg;
    logic [15:0] fill_b_reg;

    color_word_t    pending_words[$];
    adjusted_word_t expected_colors[$];
    int  mismatches;
    int  words_sent;
    int  colors_checked;
    bit  feed_hold;
    bit  hold_request;
    longint cycles;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clampl(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint absl(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint hsv_channel(longint n, longint s, longint v);
        longint t;
        n = clampl(n, 0, UNIT);
        t = (n - UNIT) * s + (longint'(1) << 32);
        return (t * v + (longint'(1) << 31)) >>> 32;
    endfunction

    function automatic void rebuild_rgb(longint h, longint s, longint v,
                                        ref longint rgb[3]);
        longint h6;
        h6 = h * 6;
        rgb[0] = hsv_channel(absl(h6 - 3 * UNIT) - UNIT, s, v);
        rgb[1] = hsv_channel(2 * UNIT - absl(h6 - 2 * UNIT), s, v);
        rgb[2] = hsv_channel(2 * UNIT - absl(h6 - 4 * UNIT), s, v);
    endfunction

    function automatic void split_hsv(longint r, longint g, longint b,
                                      output longint h, output longint s,
                                      output longint v);
        longint hi, lo, c, n;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        c = hi - lo;
        v = hi;
        // black has no saturation
        s = hi > 0 ? (c * UNIT + hi / 2) / hi : 0;
        // gray has hue zero
        if (c == 0)
        begin
            h = 0;
            return;
        end
        if (r >= g && r >= b)
        begin
            n = g - b;
            if (n < 0)
                n += 6 * c;
        end
        else if (g >= b)
            n = 2 * c + (b - r);
        else
            n = 4 * c + (r - g);
        h = ((n * UNIT + 3 * c) / (6 * c)) & 16'hFFFF;
    endfunction

    function automatic longint contrast_channel(longint x, longint c);
        longint num, den;
        num = 2 * x - c;
        if (c > 0)
        begin
            den = 2 * (UNIT - c);
            if (num <= 0)
                return 0;
            // full contrast saturates the division
            if (den == 0)
                return 65535;
            return (num * UNIT + den / 2) / den;
        end
        return ((UNIT - c) * num + (longint'(1) << 16)) >>> 17;
    endfunction

    // expected adjusted color of one input word under the current registers
    function automatic adjusted_word_t adjust_color(color_word_t w);
        adjusted_word_t o;
        longint col[3];
        longint res[3];
        longint fills[3];
        longint st, f, fc, h, s, v, oa, b;
        col[0] = longint'(w.red);
        col[1] = longint'(w.green);
        col[2] = longint'(w.blue);
        fills[0] = longint'(fill_r_reg);
        fills[1] = longint'(fill_g_reg);
        fills[2] = longint'(fill_b_reg);
        for (int i = 0; i < 3; i++)
            res[i] = col[i];
        oa = longint'(w.alpha);
        st = longint'($signed(strength_reg));
        f = (longint'(w.weight) * st + 2048) >>> 12;
        case (mode_reg)
            KIND_FILL:
            begin
                fc = clampl(f, 0, UNIT);
                for (int i = 0; i < 3; i++)
                    res[i] = ((UNIT - fc) * col[i] + fc * fills[i] + 32768) >>> 16;
                oa = ((UNIT - fc) * longint'(w.alpha) + fc * UNIT + 32768) >>> 16;
            end
            KIND_HUE:
            begin
                split_hsv(col[0], col[1], col[2], h, s, v);
                rebuild_rgb(absl(f) & 16'hFFFF, s, v, res);
            end
            KIND_SAT:
            begin
                split_hsv(col[0], col[1], col[2], h, s, v);
                if (s >= 66)
                begin
                    s = clampl(s + ((f * s + 32768) >>> 16), 0, UNIT);
                    rebuild_rgb(h, s, v, res);
                end
            end
            KIND_VALUE:
            begin
                split_hsv(col[0], col[1], col[2], h, s, v);
                v = clampl(v + f, 0, UNIT);
                rebuild_rgb(h, s, v, res);
            end
            KIND_BRIGHT:
            begin
                b = clampl(f, -UNIT, UNIT);
                for (int i = 0; i < 3; i++)
                    res[i] = col[i] + b;
            end
            KIND_CONTRAST:
            begin
                b = clampl(f, -UNIT, UNIT);
                for (int i = 0; i < 3; i++)
                    res[i] = contrast_channel(col[i], b);
            end
            KIND_RED:   res[0] = col[0] + f;
            KIND_GREEN: res[1] = col[1] + f;
            KIND_BLUE:  res[2] = col[2] + f;
            default: ;
        endcase
        o.red   = 16'(clampl(res[0], 0, 65535));
        o.green = 16'(clampl(res[1], 0, 65535));
        o.blue  = 16'(clampl(res[2], 0, 65535));
        o.alpha = 16'(clampl(oa, 0, 65535));
        return o;
    endfunction

    // driver: bursts of words with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        color_word_t nxt;
        logic take;
        if (!rst_n)
        begin
            feed_if.valid    <= 1'b0;
            feed_if.in_red   <= '0;
            feed_if.in_green <= '0;
            feed_if.in_blue  <= '0;
            feed_if.in_alpha <= '0;
            feed_if.weight   <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (feed_if.valid && feed_if.ready)
            begin
                expected_colors.push_back(adjust_color({feed_if.in_red, feed_if.in_green,
                    feed_if.in_blue, feed_if.in_alpha, feed_if.weight}));
                words_sent++;
            end
            take = 1'b0;
            if (feed_if.valid && !feed_if.ready)
                take = 1'b0;
            else if (gap_left > 0)
                gap_left--;
            else if (!feed_hold && pending_words.size() > 0)
            begin
                take = 1'b1;
                nxt = pending_words.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!(feed_if.valid && !feed_if.ready))
            begin
                feed_if.valid <= take;
                if (take)
                begin
                    feed_if.in_red   <= nxt.red;
                    feed_if.in_green <= nxt.green;
                    feed_if.in_blue  <= nxt.blue;
                    feed_if.in_alpha <= nxt.alpha;
                    feed_if.weight   <= nxt.weight;
                end
            end
        end
    end

    // monitor: compare each result word, stall on a pattern of its own
    int stall_style;
    int style_left;
    int long_hold;
    bit long_hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        adjusted_word_t exp_c;
        adjusted_word_t got;
        logic rdy;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_style = 0;
            style_left = 0;
            long_hold = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = {res_if.out_red, res_if.out_green, res_if.out_blue, res_if.out_alpha};
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, actual %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    exp_c = expected_colors.pop_front();
                    if (got.red !== exp_c.red)
                        $display("%0t: red expected %h actual %h", $time, exp_c.red, got.red);
                    if (got.green !== exp_c.green)
                        $display("%0t: green expected %h actual %h", $time, exp_c.green,
                                 got.green);
                    if (got.blue !== exp_c.blue)
                        $display("%0t: blue expected %h actual %h", $time, exp_c.blue,
                                 got.blue);
                    if (got.alpha !== exp_c.alpha)
                        $display("%0t: alpha expected %h actual %h", $time, exp_c.alpha,
                                 got.alpha);
                    if (got !== exp_c)
                        mismatches++;
                end
                colors_checked++;
            end
            // one long hold-off at the start of a full phase so the pipeline backs up
            if (!long_hold_done && hold_request)
            begin
                long_hold_done = 1'b1;
                long_hold = LONG_HOLD_CYCLES;
            end
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            else
                style_left--;
            if (long_hold > 0)
            begin
                long_hold--;
                rdy = 1'b0;
            end
            else
                case (stall_style)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 7) != 0);
                    2: rdy = ($urandom_range(0, 1) != 0);
                    default: rdy = ($urandom_range(0, 5) == 0);
                endcase
            res_if.ready <= rdy;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_KIND:       mode_reg = val[3:0];
            REG_STRENGTH:   strength_reg = val;
            REG_FILL_RED:   fill_r_reg = val;
            REG_FILL_GREEN: fill_g_reg = val;
            REG_FILL_BLUE:  fill_b_reg = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // sender pause until every expected word has come back
    task automatic drain();
        while (pending_words.size() > 0 || feed_if.valid || expected_colors.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_word(input chan_t r, input chan_t g, input chan_t b,
                            input chan_t a, input chan_t w);
        color_word_t cw;
        cw = {r, g, b, a, w};
        pending_words.push_back(cw);
    endtask

    function automatic chan_t rand_level();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic chan_t rand_strength();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'h1000;
            4: return 16'h2000;
            5: return 16'hF000;
            6: return 16'($urandom_range(0, 8192));
            7: return 16'(17'h10000 - 17'($urandom_range(1, 8192)));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // random colors with a share of gray and black ones
    task automatic add_random_words(input int count);
        chan_t r, g, b;
        for (int i = 0; i < count; i++)
        begin
            r = 16'($urandom_range(0, 65535));
            g = 16'($urandom_range(0, 65535));
            b = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 11))
                0: begin g = r; b = r; end
                1: begin r = 0; g = 0; b = 0; end
                2: begin r = rand_level(); g = rand_level(); b = rand_level(); end
                3: begin g = 16'(r + 16'($urandom_range(0, 60))); b = r; end
                default: ;
            endcase
            add_word(r, g, b, 16'($urandom_range(0, 65535)),
                     $urandom_range(0, 3) == 0 ? rand_level() :
                     16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic add_directed_words();
        add_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        add_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_word(16'h8000, 16'h8000, 16'h8000, 16'h1234, 16'h8000);
        add_word(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        add_word(16'h2000, 16'hC000, 16'h8001, 16'h0001, 16'h8000);
    endtask

    // stimulus and phases
    initial
    begin
        int kind_pick;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = REG_KIND;
        cfg_wdata = '0;
        feed_if.valid = 1'b0;
        res_if.ready = 1'b0;
        mode_reg = KIND_FILL;
        strength_reg = 16'h1000;
        fill_r_reg = 16'hFFFF;
        fill_g_reg = 16'hFFFF;
        fill_b_reg = 16'hFFFF;
        mismatches = 0;
        words_sent = 0;
        colors_checked = 0;
        feed_hold = 1'b0;
        hold_request = 1'b0;
        cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, then each mode and one undefined mode at half weight
        add_directed_words();
        drain();
        write_reg(REG_FILL_RED, 16'h0000);
        write_reg(REG_FILL_GREEN, 16'h8000);
        write_reg(REG_FILL_BLUE, 16'h1234);
        for (int k = KIND_HUE; k <= KIND_BLUE + 1; k++)
        begin
            write_reg(REG_KIND, 16'(k[3:0]));
            write_reg(REG_STRENGTH, (k == KIND_CONTRAST) ? 16'h2000 : 16'h0800);
            add_word(16'hFFFF, 16'h0000, 16'h0000, 16'hABCD, 16'h8000);
            add_word(16'h8001, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h8000);
            drain();
        end

        // random phases across settings
        for (int p = 0; p < 36; p++)
        begin
            kind_pick = $urandom_range(0, 19);
            write_reg(REG_KIND, kind_pick < 18 ? 16'(kind_pick % 9) :
                      16'($urandom_range(9, 15)));
            write_reg(REG_STRENGTH, rand_strength());
            write_reg(REG_FILL_RED, rand_level());
            write_reg(REG_FILL_GREEN, rand_level());
            write_reg(REG_FILL_BLUE, rand_level());
            // receiver holds off while a whole phase is offered
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            add_random_words(50);
            drain();
        end

        $display("Sent %0d color words and checked %0d results over all nine modes,",
                 words_sent, colors_checked);
        $display("undefined modes and strength extremes, with stalls on both sides.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
